FILE: rtl/core/wbsc_pkg.sv
// Package: shared types and constants of the word break segmentation check.
`default_nettype none
package wbsc_pkg;

  localparam int MAX_PATTERNS    = 512;
  localparam int MAX_PATTERN_LEN = 8;

  localparam int COLOR_W = 3;
  localparam int SYM_W   = COLOR_W * MAX_PATTERN_LEN;
  localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 2);
  localparam int ENTRY_W = LEN_W + SYM_W;
  localparam int ADDR_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CNT_W   = $clog2(MAX_PATTERNS + 1);
  localparam int REACH_W = MAX_PATTERN_LEN + 1;
  localparam int TOTAL_W = 32;

  localparam logic [1:0] ACT_PATTERN = 2'd0;
  localparam logic [1:0] ACT_DESIGN  = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [COLOR_W-1:0] stripe_color;
    logic               last_symbol;
  } in_t;

  typedef struct packed {
    logic               design_possible;
    logic [TOTAL_W-1:0] possible_total;
    logic               overflow_flag;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/core/wbsc_pattern_ram.sv
// Pattern table: one write port, one registered read port.
`default_nettype none
module wbsc_pattern_ram (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [wbsc_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [wbsc_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [wbsc_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [wbsc_pkg::ENTRY_W-1:0] rd_data
);

  logic [wbsc_pkg::ENTRY_W-1:0] mem [wbsc_pkg::MAX_PATTERNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/word_break_segmentation_check.sv
// Top level: dictionary word break checker over a stored pattern table.
//
//   channel  ports                         handshake
//   input    start, busy, in_data          taken when start & !busy
//   result   out_strobe, out_data          valid for one cycle, no stall
//
// Pattern symbols and clears are taken without leaving idle. A design
// symbol walks the pattern table through the one read port of the table
// memory, one entry a cycle, and the walk ends early when a match is found.
// For the last symbol of a design, the result strobe is high in the first
// cycle after busy falls. Reset empties the table through its fill count;
// no clearing pass is needed. The receiver cannot stall results.
`default_nettype none
module word_break_segmentation_check (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire wbsc_pkg::in_t  in_data,
  output logic                out_strobe,
  output wbsc_pkg::out_t      out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;

  logic [wbsc_pkg::CNT_W-1:0]   entries_r, entries_nxt;
  logic [wbsc_pkg::LEN_W-1:0]   bld_len_r, bld_len_nxt;
  logic [wbsc_pkg::SYM_W-1:0]   bld_sym_r, bld_sym_nxt;
  logic [wbsc_pkg::SYM_W-1:0]   window_r, window_nxt;
  logic [wbsc_pkg::REACH_W-1:0] reach_r, reach_nxt;
  logic [wbsc_pkg::TOTAL_W-1:0] count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [wbsc_pkg::CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                         cmp_valid_r, cmp_valid_nxt;
  logic                         last_r, last_nxt;
  logic                         out_strobe_r, out_strobe_nxt;
  wbsc_pkg::out_t               out_data_r, out_data_nxt;

  logic                         mem_we;
  logic [wbsc_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [wbsc_pkg::ENTRY_W-1:0] mem_rdata;

  logic [wbsc_pkg::LEN_W-1:0]   ent_len;
  logic [wbsc_pkg::SYM_W-1:0]   ent_sym;
  logic                         sym_eq;
  logic                         hit;
  logic [wbsc_pkg::LEN_W-1:0]   add_len;
  logic [wbsc_pkg::SYM_W-1:0]   add_sym;
  logic [wbsc_pkg::REACH_W-1:0] reach_new;
  logic                         issue_done;

  wbsc_pattern_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (entries_r[wbsc_pkg::ADDR_W-1:0]),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (rd_idx_r[wbsc_pkg::ADDR_W-1:0]),
    .rd_data (mem_rdata)
  );

  // Compare the fetched entry against the newest symbols of the window.
  always_comb begin
    ent_len = mem_rdata[wbsc_pkg::ENTRY_W-1 -: wbsc_pkg::LEN_W];
    ent_sym = mem_rdata[wbsc_pkg::SYM_W-1:0];
    sym_eq  = 1'b1;
    for (int k = 0; k < wbsc_pkg::MAX_PATTERN_LEN; k++) begin
      if ((wbsc_pkg::LEN_W'(k) < ent_len) &&
          (window_r[k*wbsc_pkg::COLOR_W +: wbsc_pkg::COLOR_W] !=
           ent_sym[k*wbsc_pkg::COLOR_W +: wbsc_pkg::COLOR_W])) begin
        sym_eq = 1'b0;
      end
    end
    hit = cmp_valid_r && sym_eq && (ent_len != '0) &&
          (ent_len <= wbsc_pkg::LEN_W'(wbsc_pkg::MAX_PATTERN_LEN)) &&
          reach_r[ent_len - wbsc_pkg::LEN_W'(1)];
  end

  assign issue_done = (rd_idx_r >= entries_r);
  assign reach_new  = {reach_r[wbsc_pkg::REACH_W-2:0], hit};

  always_comb begin
    state_nxt      = state_r;
    entries_nxt    = entries_r;
    bld_len_nxt    = bld_len_r;
    bld_sym_nxt    = bld_sym_r;
    window_nxt     = window_r;
    reach_nxt      = reach_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_valid_nxt  = cmp_valid_r;
    last_nxt       = last_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    add_len        = bld_len_r;
    add_sym        = bld_sym_r;
    mem_wdata      = {bld_len_r, bld_sym_r};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.action)
            wbsc_pkg::ACT_PATTERN: begin
              if (bld_len_r < wbsc_pkg::LEN_W'(wbsc_pkg::MAX_PATTERN_LEN)) begin
                add_sym = {bld_sym_r[wbsc_pkg::SYM_W-wbsc_pkg::COLOR_W-1:0],
                           in_data.stripe_color};
                add_len = bld_len_r + wbsc_pkg::LEN_W'(1);
              end else begin
                // too long: hold the length one past the limit
                add_len = wbsc_pkg::LEN_W'(wbsc_pkg::MAX_PATTERN_LEN + 1);
                ovf_nxt = 1'b1;
              end
              mem_wdata = {add_len, add_sym};
              if (in_data.last_symbol) begin
                if ((add_len <= wbsc_pkg::LEN_W'(wbsc_pkg::MAX_PATTERN_LEN)) &&
                    (entries_r < wbsc_pkg::CNT_W'(wbsc_pkg::MAX_PATTERNS))) begin
                  mem_we      = 1'b1;
                  entries_nxt = entries_r + wbsc_pkg::CNT_W'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
                bld_len_nxt = '0;
                bld_sym_nxt = '0;
              end else begin
                bld_len_nxt = add_len;
                bld_sym_nxt = add_sym;
              end
            end
            wbsc_pkg::ACT_DESIGN: begin
              window_nxt    = {window_r[wbsc_pkg::SYM_W-wbsc_pkg::COLOR_W-1:0],
                               in_data.stripe_color};
              last_nxt      = in_data.last_symbol;
              rd_idx_nxt    = '0;
              cmp_valid_nxt = 1'b0;
              state_nxt     = ST_WALK;
            end
            wbsc_pkg::ACT_CLEAR: begin
              entries_nxt = '0;
              bld_len_nxt = '0;
              bld_sym_nxt = '0;
              window_nxt  = '0;
              reach_nxt   = wbsc_pkg::REACH_W'(1);
              count_nxt   = '0;
              ovf_nxt     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!issue_done) begin
          mem_re        = 1'b1;
          rd_idx_nxt    = rd_idx_r + wbsc_pkg::CNT_W'(1);
          cmp_valid_nxt = 1'b1;
        end else begin
          cmp_valid_nxt = 1'b0;
        end
        // finish on the first match or once every entry is compared
        if (hit || (!cmp_valid_r && issue_done)) begin
          state_nxt     = ST_IDLE;
          cmp_valid_nxt = 1'b0;
          if (last_r) begin
            if (hit && (count_r != '1)) begin
              count_nxt = count_r + wbsc_pkg::TOTAL_W'(1);
            end
            out_strobe_nxt               = 1'b1;
            out_data_nxt.design_possible = hit;
            out_data_nxt.possible_total  = (hit && (count_r != '1)) ?
                                           count_r + wbsc_pkg::TOTAL_W'(1) : count_r;
            out_data_nxt.overflow_flag   = ovf_r;
            window_nxt                   = '0;
            reach_nxt                    = wbsc_pkg::REACH_W'(1);
          end else begin
            reach_nxt = reach_new;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      entries_r    <= '0;
      bld_len_r    <= '0;
      bld_sym_r    <= '0;
      window_r     <= '0;
      reach_r      <= wbsc_pkg::REACH_W'(1);
      count_r      <= '0;
      ovf_r        <= 1'b0;
      rd_idx_r     <= '0;
      cmp_valid_r  <= 1'b0;
      last_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      entries_r    <= entries_nxt;
      bld_len_r    <= bld_len_nxt;
      bld_sym_r    <= bld_sym_nxt;
      window_r     <= window_nxt;
      reach_r      <= reach_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      last_r       <= last_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the word break check: queue-fed driver, monitor, predictor.
module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_WHITE = 3'd0;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_BLUE  = 3'd1;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_BLACK = 3'd2;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_RED   = 3'd3;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_GREEN = 3'd4;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_CODE5 = 3'd5;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_CODE6 = 3'd6;
  localparam logic [wbsc_pkg::COLOR_W-1:0] COLOR_CODE7 = 3'd7;

  localparam int GAP_MAX      = 19;
  localparam int IDLE_LIMIT   = 8 * (wbsc_pkg::MAX_PATTERNS + 2 + GAP_MAX);
  localparam int DRAIN_CYCLES = wbsc_pkg::MAX_PATTERNS + 8;
  localparam int RANDOM_WORDS = 400;
  localparam int REPORT_MAX   = 10;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  wbsc_pkg::in_t  in_data = '0;
  logic           busy;
  logic           out_strobe;
  wbsc_pkg::out_t out_data;

  word_break_segmentation_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [wbsc_pkg::SYM_W-1:0]   dict_syms [wbsc_pkg::MAX_PATTERNS];
  int                           dict_len  [wbsc_pkg::MAX_PATTERNS];
  int                           dict_count;
  logic [wbsc_pkg::SYM_W-1:0]   build_syms;
  int                           build_len;
  logic [wbsc_pkg::SYM_W-1:0]   recent_syms;
  logic [wbsc_pkg::REACH_W-1:0] reach;
  logic [wbsc_pkg::TOTAL_W-1:0] split_tally;
  logic                         dropped_flag;
  wbsc_pkg::out_t               verdicts_due [$];

  int err_count = 0;

  task automatic clear_dictionary();
    dict_count   = 0;
    build_syms   = '0;
    build_len    = 0;
    recent_syms  = '0;
    reach        = wbsc_pkg::REACH_W'(1);
    split_tally  = '0;
    dropped_flag = 1'b0;
  endtask

  task automatic predict_word(input wbsc_pkg::in_t w);
    logic [wbsc_pkg::SYM_W-1:0] mask;
    logic                       hit;
    int                         n;
    wbsc_pkg::out_t             v;
    case (w.action)
      wbsc_pkg::ACT_PATTERN: begin
        if (build_len < wbsc_pkg::MAX_PATTERN_LEN) begin
          build_syms = {build_syms[wbsc_pkg::SYM_W-wbsc_pkg::COLOR_W-1:0], w.stripe_color};
          build_len++;
        end else begin
          build_len    = wbsc_pkg::MAX_PATTERN_LEN + 1;
          dropped_flag = 1'b1;
        end
        if (w.last_symbol) begin
          if (build_len <= wbsc_pkg::MAX_PATTERN_LEN &&
              dict_count < wbsc_pkg::MAX_PATTERNS) begin
            dict_syms[dict_count] = build_syms;
            dict_len[dict_count]  = build_len;
            dict_count++;
          end else begin
            dropped_flag = 1'b1;
          end
          build_syms = '0;
          build_len  = 0;
        end
      end
      wbsc_pkg::ACT_CLEAR: clear_dictionary();
      wbsc_pkg::ACT_DESIGN: begin
        recent_syms = {recent_syms[wbsc_pkg::SYM_W-wbsc_pkg::COLOR_W-1:0], w.stripe_color};
        hit = 1'b0;
        for (int i = 0; i < dict_count && !hit; i++) begin
          n    = dict_len[i];
          mask = {wbsc_pkg::SYM_W{1'b1}} >> (wbsc_pkg::SYM_W - wbsc_pkg::COLOR_W * n);
          if (reach[n-1] && ((recent_syms & mask) == dict_syms[i]))
            hit = 1'b1;
        end
        reach = {reach[wbsc_pkg::REACH_W-2:0], hit};
        if (w.last_symbol) begin
          if (reach[0] && split_tally != {wbsc_pkg::TOTAL_W{1'b1}})
            split_tally++;
          v.design_possible = reach[0];
          v.possible_total  = split_tally;
          v.overflow_flag   = dropped_flag;
          verdicts_due.insert(verdicts_due.size(), v);
          recent_syms = '0;
          reach       = wbsc_pkg::REACH_W'(1);
        end
      end
      default: ;
    endcase
  endtask

  // Stimulus generation
  wbsc_pkg::in_t              word_queue [$];
  logic [wbsc_pkg::SYM_W-1:0] known_syms [$];
  int                         known_len  [$];

  task automatic push_word(input logic [1:0] act, input logic [wbsc_pkg::COLOR_W-1:0] c,
                           input logic lst);
    wbsc_pkg::in_t w;
    w.action       = act;
    w.stripe_color = c;
    w.last_symbol  = lst;
    word_queue.insert(word_queue.size(), w);
  endtask

  function automatic logic [wbsc_pkg::COLOR_W-1:0] pick_color();
    if ($urandom_range(0, 99) < 88)
      return wbsc_pkg::COLOR_W'($urandom_range(COLOR_WHITE, COLOR_GREEN));
    return wbsc_pkg::COLOR_W'($urandom_range(COLOR_CODE5, COLOR_CODE7));
  endfunction

  task automatic forget_dictionary();
    push_word(wbsc_pkg::ACT_CLEAR, pick_color(), 1'($urandom_range(0, 1)));
    known_syms.delete();
    known_len.delete();
  endtask

  task automatic send_pattern(input int n);
    logic [wbsc_pkg::SYM_W-1:0]   syms;
    logic [wbsc_pkg::COLOR_W-1:0] c;
    syms = '0;
    for (int k = 0; k < n; k++) begin
      c    = pick_color();
      syms = {syms[wbsc_pkg::SYM_W-wbsc_pkg::COLOR_W-1:0], c};
      push_word(wbsc_pkg::ACT_PATTERN, c, k == n - 1);
    end
    if (n <= wbsc_pkg::MAX_PATTERN_LEN) begin
      known_syms.insert(known_syms.size(), syms);
      known_len.insert(known_len.size(), n);
    end
  endtask

  // Build a design mostly from known patterns so that splits succeed often
  task automatic send_design(input int parts);
    logic [wbsc_pkg::SYM_W-1:0] s;
    int                         pick;
    int                         n;
    int                         tail;
    wbsc_pkg::in_t              w;
    tail = 0;
    for (int p = 0; p < parts; p++) begin
      if (p > 0 && $urandom_range(0, 9) == 0)
        send_pattern($urandom_range(1, 4));
      if (known_len.size() != 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, known_len.size() - 1);
        n    = known_len[pick];
        s    = known_syms[pick];
        for (int k = 0; k < n; k++)
          push_word(wbsc_pkg::ACT_DESIGN, s[wbsc_pkg::COLOR_W*(n-1-k) +: wbsc_pkg::COLOR_W],
                    1'b0);
      end else begin
        push_word(wbsc_pkg::ACT_DESIGN, pick_color(), 1'b0);
      end
      tail = word_queue.size() - 1;
    end
    w = word_queue[tail];
    w.last_symbol = 1'b1;
    word_queue[tail] = w;
  endtask

  // Driver
  int   gap_cnt = 0;
  logic no_gap  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        predict_word(in_data);
      if (!start || !busy) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          start   <= 1'b0;
        end else if (word_queue.size() != 0) begin
          in_data <= word_queue.pop_front();
          start   <= 1'b1;
          if ($urandom_range(0, 29) == 0)
            no_gap <= !no_gap;
          gap_cnt <= no_gap ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    wbsc_pkg::out_t e;
    if (rst_n && out_strobe) begin
      if (verdicts_due.size() == 0) begin
        if (err_count < REPORT_MAX)
          $display("unexpected result: possible=%0d total=%0d overflow=%0d",
                   out_data.design_possible, out_data.possible_total,
                   out_data.overflow_flag);
        err_count++;
      end else begin
        e = verdicts_due.pop_front();
        if (out_data.design_possible != e.design_possible ||
            out_data.possible_total  != e.possible_total ||
            out_data.overflow_flag   != e.overflow_flag) begin
          if (err_count < REPORT_MAX)
            $display("mismatch: possible %0d/%0d total %0d/%0d overflow %0d/%0d (exp/act)",
                     e.design_possible, out_data.design_possible,
                     e.possible_total, out_data.possible_total,
                     e.overflow_flag, out_data.overflow_flag);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles with no word accepted and no result
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int base;
    int noise_words;
    int roll;
    clear_dictionary();

    // Directed words
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_WHITE, 1'b1);          // empty dictionary
    push_word(wbsc_pkg::ACT_PATTERN, COLOR_WHITE, 1'b1);
    push_word(wbsc_pkg::ACT_PATTERN, COLOR_BLUE, 1'b0);
    push_word(wbsc_pkg::ACT_PATTERN, COLOR_BLACK, 1'b1);
    push_word(wbsc_pkg::ACT_PATTERN, COLOR_CODE7, 1'b1);
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_WHITE, 1'b0);
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_BLUE, 1'b0);
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_BLACK, 1'b1);
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_CODE7, 1'b1);          // high code matches itself
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_CODE5, 1'b1);          // no such pattern
    push_word(ACT_UNUSED, COLOR_CODE6, 1'b1);
    for (int k = 0; k <= wbsc_pkg::MAX_PATTERN_LEN; k++)
      push_word(wbsc_pkg::ACT_PATTERN, COLOR_GREEN, k == wbsc_pkg::MAX_PATTERN_LEN); // too long
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_GREEN, 1'b1);
    push_word(wbsc_pkg::ACT_PATTERN, COLOR_RED, 1'b1);
    push_word(wbsc_pkg::ACT_CLEAR, COLOR_WHITE, 1'b0);
    push_word(wbsc_pkg::ACT_DESIGN, COLOR_RED, 1'b1);

    // Fill the table past its capacity, then run designs over a full table
    forget_dictionary();
    for (int i = 0; i <= wbsc_pkg::MAX_PATTERNS; i++)
      send_pattern(1);
    send_pattern(2);
    repeat (6) send_design($urandom_range(1, 3));
    forget_dictionary();

    base        = word_queue.size();
    noise_words = 0;
    while (word_queue.size() - base - noise_words < RANDOM_WORDS) begin
      if (known_len.size() > 40)
        forget_dictionary();
      roll = $urandom_range(0, 99);
      if (roll < 35)
        send_pattern(roll < 3 ? $urandom_range(wbsc_pkg::MAX_PATTERN_LEN + 1,
                                               wbsc_pkg::MAX_PATTERN_LEN + 3)
                              : $urandom_range(1, wbsc_pkg::MAX_PATTERN_LEN));
      else if (roll < 92)
        send_design($urandom_range(1, 4));
      else if (roll < 95)
        forget_dictionary();
      else begin
        push_word(ACT_UNUSED, wbsc_pkg::COLOR_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
        noise_words++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || start)
      @(posedge clk);
    while (verdicts_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (verdicts_due.size() != 0)
      err_count++;
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
